// File: design/zrms_pkg.sv
// Shared types and constants for the zone range match sorter.
package zrms_pkg;

    localparam int MAX_ZONES_DEF = 32;
    localparam int ID_W          = 16;
    localparam int BND_W         = 7;
    localparam int SPAN_W        = BND_W + 1;
    localparam int AREA_W        = 15;

    // One stored zone, id in the lowest bits
    typedef struct packed {
        logic [BND_W-1:0] vh;
        logic [BND_W-1:0] vl;
        logic [BND_W-1:0] kh;
        logic [BND_W-1:0] kl;
        logic [ID_W-1:0]  id;
    } zone_t;

    localparam int ENTRY_W = $bits(zone_t);

    // Range bounds only, used as the exact stack reference
    typedef struct packed {
        logic [BND_W-1:0] vh;
        logic [BND_W-1:0] vl;
        logic [BND_W-1:0] kh;
        logic [BND_W-1:0] kl;
    } bounds_t;

    // Per-entry evaluation flags and area
    typedef struct packed {
        logic              hit;
        logic              is_excl;
        logic              exact;
        logic [AREA_W-1:0] area;
    } eval_t;

    // Item kinds
    localparam logic KIND_APPEND = 1'b0;
    localparam logic KIND_QUERY  = 1'b1;

endpackage

// File: design/zrms_ram.sv
// Generic single-port-write, registered-read RAM.
module zrms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: design/zrms_eval.sv
// Evaluates one stored zone against the query point and builds its sort key.
module zrms_eval #(
    parameter int IW = 5,
    parameter int SW = 1 + zrms_pkg::AREA_W + zrms_pkg::ID_W + IW
) (
    input  zrms_pkg::zone_t              zone,
    input  logic [IW-1:0]                idx,
    input  logic [zrms_pkg::BND_W-1:0]   key,
    input  logic [zrms_pkg::BND_W-1:0]   vel,
    input  logic [zrms_pkg::ID_W-1:0]    excl,
    input  logic                         ref_valid,
    input  zrms_pkg::bounds_t            ref_bnd,
    output zrms_pkg::eval_t              ev,
    output logic [SW-1:0]                sort_key
);

    logic [zrms_pkg::SPAN_W-1:0]   kspan;
    logic [zrms_pkg::SPAN_W-1:0]   vspan;
    logic [2*zrms_pkg::SPAN_W-1:0] prod;
    logic                          inside_pt;

    // Containment, exclusion, stack match and area
    always_comb
    begin
        kspan = zrms_pkg::SPAN_W'(zone.kh) - zrms_pkg::SPAN_W'(zone.kl) + 1'b1;
        vspan = zrms_pkg::SPAN_W'(zone.vh) - zrms_pkg::SPAN_W'(zone.vl) + 1'b1;
        prod  = kspan * vspan;
        inside_pt = (key >= zone.kl) && (key <= zone.kh) &&
                    (vel >= zone.vl) && (vel <= zone.vh);
        ev.is_excl = (zone.id == excl);
        ev.hit     = inside_pt && !ev.is_excl;
        ev.exact   = ref_valid && (zone.kl == ref_bnd.kl) && (zone.kh == ref_bnd.kh) &&
                     (zone.vl == ref_bnd.vl) && (zone.vh == ref_bnd.vh);
        ev.area    = prod[zrms_pkg::AREA_W-1:0];
        // Ascending key: exact first, larger area, smaller id, table order
        sort_key   = {~ev.exact, ~ev.area, zone.id, idx};
    end

endmodule

// File: design/zone_range_match_sorter.sv
// Zone table with point query; emits matches in sorted order.
// Append: one item per cycle while idle. Query: a reference/count scan over the stored
// zones, then for each match a selection scan and an emit, bounded by the single zone
// RAM read port; with no match, a single not-found result (found = 0) is emitted.
// A result leaves through an output register; the next scan overlaps its wait.
// rst_n clears the zone count and control state; RAM contents are not cleared.
module zone_range_match_sorter #(
    parameter int MAX_ZONES = zrms_pkg::MAX_ZONES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // zone_id, key_low, key_high, vel_low, vel_high, key, velocity, exclude_id, pad
    input  logic [79:0] s_axis_tdata,
    // kind, restart
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // match_id, match_key_low, match_key_high, match_vel_low, match_vel_high, area, pad
    output logic [63:0] m_axis_tdata,
    // found, exact_stack
    output logic [1:0]  m_axis_tuser,
    output logic        m_axis_tlast
);

    localparam int IW = (MAX_ZONES > 1) ? $clog2(MAX_ZONES) : 1;
    localparam int CW = $clog2(MAX_ZONES + 1);
    localparam int SW = 1 + zrms_pkg::AREA_W + zrms_pkg::ID_W + IW;
    localparam int BW = zrms_pkg::BND_W;

    typedef enum logic [1:0] {ST_IDLE, ST_REF, ST_PASS, ST_EMIT} state_t;

    state_t                       state_reg, state_next;
    logic [CW-1:0]                count_reg, count_next;
    logic [CW-1:0]                iss_reg, iss_next;
    logic                         pend_reg, pend_next;
    logic [IW-1:0]                pidx_reg, pidx_next;
    logic [BW-1:0]                key_reg, key_next;
    logic [BW-1:0]                vel_reg, vel_next;
    logic [zrms_pkg::ID_W-1:0]    excl_reg, excl_next;
    logic                         refv_reg, refv_next;
    zrms_pkg::bounds_t            refb_reg, refb_next;
    logic [CW-1:0]                cnt_reg, cnt_next;
    logic [CW-1:0]                emit_reg, emit_next;
    logic                         first_reg, first_next;
    logic [SW-1:0]                prev_reg, prev_next;
    logic                         bestv_reg, bestv_next;
    logic [SW-1:0]                bkey_reg, bkey_next;
    zrms_pkg::zone_t              bzone_reg, bzone_next;
    logic [zrms_pkg::AREA_W-1:0]  barea_reg, barea_next;
    logic                         bexact_reg, bexact_next;
    logic                         ovalid_reg, ovalid_next;
    logic [63:0]                  odata_reg, odata_next;
    logic [1:0]                   ouser_reg, ouser_next;
    logic                         olast_reg, olast_next;

    logic                         in_acc;
    logic                         issue;
    logic                         scan_done;
    logic                         is_last;
    logic [CW-1:0]                cnt_base;
    logic                         ram_we;
    logic [IW-1:0]                ram_waddr;
    zrms_pkg::zone_t              wzone;
    zrms_pkg::zone_t              rzone;
    logic [zrms_pkg::ENTRY_W-1:0] rdata;
    zrms_pkg::eval_t              ev;
    logic [SW-1:0]                skey;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = odata_reg;
    assign m_axis_tuser  = ouser_reg;
    assign m_axis_tlast  = olast_reg;

    // Unpack the appended zone
    always_comb
    begin
        wzone.id = s_axis_tdata[15:0];
        wzone.kl = s_axis_tdata[22:16];
        wzone.kh = s_axis_tdata[29:23];
        wzone.vl = s_axis_tdata[36:30];
        wzone.vh = s_axis_tdata[43:37];
    end

    // Append address after an optional restart
    assign cnt_base  = s_axis_tuser[1] ? '0 : count_reg;
    assign ram_we    = in_acc && (s_axis_tuser[0] == zrms_pkg::KIND_APPEND) &&
                       (cnt_base < CW'(MAX_ZONES));
    assign ram_waddr = cnt_base[IW-1:0];

    zrms_ram #(
        .WIDTH(zrms_pkg::ENTRY_W),
        .DEPTH(MAX_ZONES)
    ) u_zone_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(wzone),
        .raddr(iss_reg[IW-1:0]),
        .rdata(rdata)
    );

    assign rzone = rdata;

    zrms_eval #(
        .IW(IW)
    ) u_eval (
        .zone     (rzone),
        .idx      (pidx_reg),
        .key      (key_reg),
        .vel      (vel_reg),
        .excl     (excl_reg),
        .ref_valid(refv_reg),
        .ref_bnd  (refb_reg),
        .ev       (ev),
        .sort_key (skey)
    );

    // Scan address issue and completion
    assign issue     = ((state_reg == ST_REF) || (state_reg == ST_PASS)) &&
                       (iss_reg < count_reg);
    assign scan_done = ((state_reg == ST_REF) || (state_reg == ST_PASS)) &&
                       !issue && !pend_reg;
    assign is_last   = ((emit_reg + 1'b1) == cnt_reg);

    // Next-state logic
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        iss_next    = iss_reg;
        pend_next   = issue;
        pidx_next   = iss_reg[IW-1:0];
        key_next    = key_reg;
        vel_next    = vel_reg;
        excl_next   = excl_reg;
        refv_next   = refv_reg;
        refb_next   = refb_reg;
        cnt_next    = cnt_reg;
        emit_next   = emit_reg;
        first_next  = first_reg;
        prev_next   = prev_reg;
        bestv_next  = bestv_reg;
        bkey_next   = bkey_reg;
        bzone_next  = bzone_reg;
        barea_next  = barea_reg;
        bexact_next = bexact_reg;
        ovalid_next = ovalid_reg && !m_axis_tready;
        odata_next  = odata_reg;
        ouser_next  = ouser_reg;
        olast_next  = olast_reg;

        if (issue)
        begin
            iss_next = iss_reg + 1'b1;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (s_axis_tuser[0] == zrms_pkg::KIND_QUERY)
                    begin
                        key_next   = s_axis_tdata[50:44];
                        vel_next   = s_axis_tdata[57:51];
                        excl_next  = s_axis_tdata[73:58];
                        iss_next   = '0;
                        cnt_next   = '0;
                        emit_next  = '0;
                        refv_next  = 1'b0;
                        state_next = ST_REF;
                    end
                    else if (ram_we)
                    begin
                        count_next = cnt_base + 1'b1;
                    end
                    else
                    begin
                        count_next = cnt_base;
                    end
                end
            end
            ST_REF:
            begin
                // Count matches and capture the first excluded zone as reference
                if (pend_reg)
                begin
                    if (ev.hit)
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                    if (ev.is_excl && !refv_reg)
                    begin
                        refv_next = 1'b1;
                        refb_next = {rzone.vh, rzone.vl, rzone.kh, rzone.kl};
                    end
                end
                if (scan_done)
                begin
                    iss_next   = '0;
                    bestv_next = 1'b0;
                    first_next = 1'b1;
                    state_next = (cnt_reg == '0) ? ST_EMIT : ST_PASS;
                end
            end
            ST_PASS:
            begin
                // Keep the smallest key above the one emitted last
                if (pend_reg && ev.hit && (first_reg || (skey > prev_reg)) &&
                    (!bestv_reg || (skey < bkey_reg)))
                begin
                    bestv_next  = 1'b1;
                    bkey_next   = skey;
                    bzone_next  = rzone;
                    barea_next  = ev.area;
                    bexact_next = ev.exact;
                end
                if (scan_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!ovalid_reg || m_axis_tready)
                begin
                    ovalid_next = 1'b1;
                    if (cnt_reg == '0)
                    begin
                        odata_next = '0;
                        ouser_next = 2'b00;
                        olast_next = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        odata_next = {5'd0, barea_reg, bzone_reg.vh, bzone_reg.vl,
                                      bzone_reg.kh, bzone_reg.kl, bzone_reg.id};
                        ouser_next = {bexact_reg, 1'b1};
                        olast_next = is_last;
                        emit_next  = emit_reg + 1'b1;
                        prev_next  = bkey_reg;
                        first_next = 1'b0;
                        iss_next   = '0;
                        bestv_next = 1'b0;
                        state_next = is_last ? ST_IDLE : ST_PASS;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            iss_reg    <= '0;
            pend_reg   <= 1'b0;
            pidx_reg   <= '0;
            key_reg    <= '0;
            vel_reg    <= '0;
            excl_reg   <= '0;
            refv_reg   <= 1'b0;
            refb_reg   <= '0;
            cnt_reg    <= '0;
            emit_reg   <= '0;
            first_reg  <= 1'b1;
            prev_reg   <= '0;
            bestv_reg  <= 1'b0;
            bkey_reg   <= '0;
            bzone_reg  <= '0;
            barea_reg  <= '0;
            bexact_reg <= 1'b0;
            ovalid_reg <= 1'b0;
            odata_reg  <= '0;
            ouser_reg  <= '0;
            olast_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            iss_reg    <= iss_next;
            pend_reg   <= pend_next;
            pidx_reg   <= pidx_next;
            key_reg    <= key_next;
            vel_reg    <= vel_next;
            excl_reg   <= excl_next;
            refv_reg   <= refv_next;
            refb_reg   <= refb_next;
            cnt_reg    <= cnt_next;
            emit_reg   <= emit_next;
            first_reg  <= first_next;
            prev_reg   <= prev_next;
            bestv_reg  <= bestv_next;
            bkey_reg   <= bkey_next;
            bzone_reg  <= bzone_next;
            barea_reg  <= barea_next;
            bexact_reg <= bexact_next;
            ovalid_reg <= ovalid_next;
            odata_reg  <= odata_next;
            ouser_reg  <= ouser_next;
            olast_reg  <= olast_next;
        end
    end

`ifndef NO_ASSERTIONS
    // No zone read is in flight while items are accepted
    a_idle_no_read: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> !pend_reg)
        else $error("zone read pending while idle");

    // Table fill never exceeds capacity
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_ZONES))
        else $error("zone count above capacity");

    // Emitted results never outnumber counted matches
    a_emit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        emit_reg <= cnt_reg)
        else $error("more results than matches");

    // Each selection pass finds a match while more remain
    a_best_found: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && cnt_reg != '0) |-> bestv_reg)
        else $error("selection pass found no match");

    // Sort keys of successive results strictly increase
    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && cnt_reg != '0 && !first_reg) |-> (bkey_reg > prev_reg))
        else $error("results out of order");
`endif

endmodule
